// ----- hw/rtl/crx_pkg.sv -----
// Shared types and constants for the character range expander.
package crx_pkg;

	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = $clog2(QueueDepth);

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_string;
	} in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_valid_char;
		logic       string_done;
		logic       error;
		logic       last;
	} out_t;

	// One unit of work for the back end: either a run of characters from lo
	// to hi inclusive, or the closing result of a string.
	typedef struct packed {
		logic       is_close;
		logic       err;
		logic [7:0] lo;
		logic [7:0] hi;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ----- hw/rtl/crx_front.sv -----
// Front end: classifies each byte, tracks range state and issues commands.
module crx_front import crx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_t       item,
	input  logic      item_valid,
	output logic      item_stall,
	input  q_status_t q_status,
	output logic      push,
	output cmd_t      push_cmd
);

	localparam logic [1:0] CLS_NONE  = 2'd0;
	localparam logic [1:0] CLS_UPPER = 2'd1;
	localparam logic [1:0] CLS_LOWER = 2'd2;
	localparam logic [1:0] CLS_DIGIT = 2'd3;
	localparam logic [7:0] DASH_CHAR = 8'h2D;

	function automatic logic [1:0] char_class(input logic [7:0] c);
		logic [1:0] r;
		r = CLS_NONE;
		if (c >= 8'd65 && c <= 8'd90) r = CLS_UPPER;
		else if (c >= 8'd97 && c <= 8'd122) r = CLS_LOWER;
		else if (c >= 8'd48 && c <= 8'd57) r = CLS_DIGIT;
		return r;
	endfunction

	logic [7:0] prev_q;
	logic       have_q;
	logic       dash_q;
	logic       failed_q;

	logic [7:0] prev_d;
	logic       have_d;
	logic       dash_d;
	logic       failed_d;

	logic       accept;
	logic       gen;
	logic [1:0] cls;
	logic [1:0] prev_cls;

	assign item_stall = q_status.full;
	assign accept     = item_valid && !item_stall;
	assign cls        = char_class(item.in_char);
	assign prev_cls   = char_class(prev_q);
	assign push       = accept && gen;

	always_comb begin
		prev_d   = prev_q;
		have_d   = have_q;
		dash_d   = dash_q;
		failed_d = failed_q;
		gen      = 1'b0;
		push_cmd = '{is_close: 1'b1, err: 1'b1, lo: 8'd0, hi: 8'd0};
		if (item.end_of_string) begin
			// Every string end returns to the reset state; a failed string
			// already reported its close.
			prev_d   = 8'd0;
			have_d   = 1'b0;
			dash_d   = 1'b0;
			failed_d = 1'b0;
			gen      = !failed_q;
			push_cmd.err = dash_q;
		end else if (failed_q) begin
			gen = 1'b0;
		end else if (dash_q) begin
			if (cls == CLS_NONE || cls != prev_cls || item.in_char < prev_q) begin
				failed_d = 1'b1;
				dash_d   = 1'b0;
				gen      = 1'b1;
			end else begin
				// A range whose ends are equal produces nothing.
				gen      = item.in_char != prev_q;
				push_cmd = '{is_close: 1'b0, err: 1'b0,
					lo: prev_q + 8'd1, hi: item.in_char};
				prev_d   = item.in_char;
				dash_d   = 1'b0;
			end
		end else if (item.in_char == DASH_CHAR) begin
			if (!have_q) begin
				failed_d = 1'b1;
				gen      = 1'b1;
			end else begin
				dash_d = 1'b1;
			end
		end else if (cls == CLS_NONE) begin
			failed_d = 1'b1;
			gen      = 1'b1;
		end else begin
			gen      = 1'b1;
			push_cmd = '{is_close: 1'b0, err: 1'b0, lo: item.in_char, hi: item.in_char};
			prev_d   = item.in_char;
			have_d   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 8'd0;
			have_q   <= 1'b0;
			dash_q   <= 1'b0;
			failed_q <= 1'b0;
		end else if (accept) begin
			prev_q   <= prev_d;
			have_q   <= have_d;
			dash_q   <= dash_d;
			failed_q <= failed_d;
		end
	end

endmodule

// ----- hw/rtl/crx_queue.sv -----
// Small command queue between the front end and the back end.
module crx_queue import crx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      head,
	output q_status_t status
);

	cmd_t                 slots_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueuePtrW:0]   count_q;

	assign head         = slots_q[rd_ptr_q];
	assign status.full  = count_q == (QueuePtrW+1)'(QueueDepth);
	assign status.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- hw/rtl/crx_back.sv -----
// Back end: walks each command's run and drives the registered result.
module crx_back import crx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      head,
	input  q_status_t q_status,
	output logic      pop,
	output out_t      result,
	output logic      result_valid,
	input  logic      result_stall
);

	logic [7:0] cur_q;
	logic       started_q;
	logic       out_vld_q;
	out_t       out_q;

	logic       advance;
	logic       emit;
	logic [7:0] value;
	logic       run_end;

	assign advance      = !out_vld_q || !result_stall;
	assign emit         = advance && !q_status.empty;
	assign value        = started_q ? cur_q : head.lo;
	assign run_end      = head.is_close || value == head.hi;
	assign pop          = emit && run_end;
	assign result       = out_q;
	assign result_valid = out_vld_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			if (head.is_close) begin
				out_q <= '{out_char: 8'd0, out_valid_char: 1'b0, string_done: 1'b1,
					error: head.err, last: 1'b1};
			end else begin
				out_q <= '{out_char: value, out_valid_char: 1'b1, string_done: 1'b0,
					error: 1'b0, last: run_end};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= 8'd0;
			started_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (advance) out_vld_q <= emit;
			if (emit) begin
				if (run_end) begin
					started_q <= 1'b0;
				end else begin
					started_q <= 1'b1;
					cur_q     <= value + 8'd1;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/character_range_expander.sv -----
// Top level of the character range expander.
// Bytes of a string enter one per transfer and letters and digits come out
// as they are, while a dash between two characters of the same class
// expands into the run between them. The front end takes one byte a cycle
// until its four-entry command queue is full; the back end delivers one
// result a cycle through its output register while result_stall is low,
// and a range of n characters gives n results of the back end.
// Every string end gives one closing result unless an error already closed
// it; after an error the rest of the string is dropped.
module character_range_expander import crx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  in_t  item,
	input  logic item_valid,
	output logic item_stall,
	output out_t result,
	output logic result_valid,
	input  logic result_stall
);

	logic      push;
	cmd_t      push_cmd;
	logic      pop;
	cmd_t      head;
	q_status_t q_status;

	crx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.q_status   (q_status),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	crx_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	crx_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule

// ----- hw/rtl/crx_checker.sv -----
// Port-level checks for the character range expander, bound to the top level.
module crx_checker import crx_pkg::*; (
	input logic clk,
	input logic arst_n,
	input in_t  item,
	input logic item_valid,
	input logic item_stall,
	input out_t result,
	input logic result_valid,
	input logic result_stall
);

	// A closing result always ends the results of its input byte.
	a_close_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.string_done |-> result.last)
		else $error("closing result without last");

	a_char_not_close: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.out_valid_char |-> !result.string_done && !result.error)
		else $error("character result marked as closing or error");

	a_error_closes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.error |-> result.string_done && !result.out_valid_char)
		else $error("error result does not close the string");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result dropped or changed");

	a_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("stalled input dropped or changed");

endmodule

bind character_range_expander crx_checker u_crx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item         (item),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result       (result),
	.result_valid (result_valid),
	.result_stall (result_stall)
);
